>>> rtl/fcskc_pkg.sv
`timescale 1ns / 1ps

package fcskc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int KEY_W   = 32;
	localparam int SPAN_W  = 16;
	localparam int AGE_W   = 32;
	localparam int SUM_W   = 32;
	localparam int LIMIT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

	typedef struct packed {
		logic [KEY_W-1:0]  entry_key;
		logic [SPAN_W-1:0] span_length;
	} req_word_t;

	typedef struct packed {
		logic [5:0]       slot_used;
		logic             replaced;
		logic [6:0]       entry_count;
		logic [SUM_W-1:0] span_total;
	} rsp_word_t;

endpackage

>>> rtl/fifo_cache_store_with_key_cap.sv
`timescale 1ns / 1ps

// Each accepted word is compared in ST_SCAN against the n valid entries before the store
//   (an empty table skips the scan), then ST_WRITE stores it and registers the result word.
// No new word is taken until ST_WRITE is done; the scan reads one table entry per cycle
//   through the single read port of the table.
// A new word is accepted while the previous result still waits on a stalled output.
// Reset: asynchronous, active low; clears counters, span total and limit (to 4);
//   table contents are not cleared and no clearing pass runs.
module fifo_cache_store_with_key_cap (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  fcskc_pkg::req_word_t                 req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output fcskc_pkg::rsp_word_t                 rsp,
	input  logic                                 cfg_we,
	input  logic [fcskc_pkg::LIMIT_W-1:0]        cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t state_q;

	logic [fcskc_pkg::KEY_W-1:0] key_mem [fcskc_pkg::TABLE_DEPTH];
	logic [fcskc_pkg::AGE_W-1:0] age_mem [fcskc_pkg::TABLE_DEPTH];

	logic [fcskc_pkg::KEY_W-1:0]   key_q;
	logic [fcskc_pkg::SPAN_W-1:0]  span_q;
	logic [fcskc_pkg::LIMIT_W-1:0] limit_q;
	logic [fcskc_pkg::AGE_W-1:0]   next_seq_q;
	logic [fcskc_pkg::CNT_W-1:0]   valid_cnt_q;
	logic [fcskc_pkg::SUM_W-1:0]   span_sum_q;

	logic [fcskc_pkg::CNT_W-1:0]   scan_cnt_q;
	logic                          rd_vld_s1;
	logic [fcskc_pkg::IDX_W-1:0]   rd_idx_s1;
	logic [fcskc_pkg::KEY_W-1:0]   rd_key_s1;
	logic [fcskc_pkg::AGE_W-1:0]   rd_age_s1;

	logic [fcskc_pkg::CNT_W-1:0]   same_q;
	logic [fcskc_pkg::IDX_W-1:0]   oldest_q;
	logic [fcskc_pkg::AGE_W-1:0]   min_age_q;

	logic                          rsp_valid_q;
	fcskc_pkg::rsp_word_t          rsp_q;

	logic                          req_take;
	logic                          rd_en;
	logic                          rd_last;
	logic                          take_oldest;
	logic                          rsp_free;
	logic                          replace;
	logic [fcskc_pkg::IDX_W-1:0]   slot;
	logic [fcskc_pkg::SUM_W:0]     sum_wide;
	logic [fcskc_pkg::SUM_W-1:0]   sum_sat;
	logic [fcskc_pkg::CNT_W-1:0]   cnt_next;
	logic [fcskc_pkg::SUM_W-1:0]   sum_next;
	logic                          do_write;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign rd_en   = (state_q == ST_SCAN) && (scan_cnt_q < valid_cnt_q);
	assign rd_last = rd_vld_s1 &&
		((fcskc_pkg::CNT_W'(rd_idx_s1) + fcskc_pkg::CNT_W'(1)) == valid_cnt_q);
	assign take_oldest = (rd_idx_s1 == '0) || (rd_age_s1 < min_age_q);

	always_comb begin
		replace  = (valid_cnt_q != '0) &&
			((fcskc_pkg::LIMIT_W'(same_q) >= limit_q) ||
			 (valid_cnt_q == fcskc_pkg::CNT_W'(fcskc_pkg::TABLE_DEPTH)));
		sum_wide = {1'b0, span_sum_q} + (fcskc_pkg::SUM_W + 1)'(span_q);
		sum_sat  = sum_wide[fcskc_pkg::SUM_W] ? '1 : sum_wide[fcskc_pkg::SUM_W-1:0];
		if (replace) begin
			slot     = oldest_q;
			cnt_next = valid_cnt_q;
			sum_next = span_sum_q;
		end else begin
			slot     = valid_cnt_q[fcskc_pkg::IDX_W-1:0];
			cnt_next = valid_cnt_q + fcskc_pkg::CNT_W'(1);
			sum_next = sum_sat;
		end
		do_write = (state_q == ST_WRITE) && rsp_free;
	end

	// table memories: one read port for the scan, one write port for the store
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_s1 <= key_mem[scan_cnt_q[fcskc_pkg::IDX_W-1:0]];
			rd_age_s1 <= age_mem[scan_cnt_q[fcskc_pkg::IDX_W-1:0]];
		end
		if (do_write) begin
			key_mem[slot] <= key_q;
			age_mem[slot] <= next_seq_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			key_q  <= req.entry_key;
			span_q <= req.span_length;
		end
		if (rd_en) begin
			rd_idx_s1 <= scan_cnt_q[fcskc_pkg::IDX_W-1:0];
		end
		if (rd_vld_s1 && take_oldest) begin
			oldest_q  <= rd_idx_s1;
			min_age_q <= rd_age_s1;
		end
		if (do_write) begin
			rsp_q.slot_used   <= 6'(slot);
			rsp_q.replaced    <= replace;
			rsp_q.entry_count <= 7'(cnt_next);
			rsp_q.span_total  <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= fcskc_pkg::LIMIT_RESET;
			next_seq_q  <= '0;
			valid_cnt_q <= '0;
			span_sum_q  <= '0;
			scan_cnt_q  <= '0;
			same_q      <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			rd_vld_s1 <= rd_en;
			if (rsp_valid_q && !rsp_stall && !do_write) begin
				rsp_valid_q <= 1'b0;
			end
			if (rd_en) begin
				scan_cnt_q <= scan_cnt_q + fcskc_pkg::CNT_W'(1);
			end
			if (rd_vld_s1 && (rd_key_s1 == key_q)) begin
				same_q <= same_q + fcskc_pkg::CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						scan_cnt_q <= '0;
						same_q     <= '0;
						state_q    <= (valid_cnt_q == '0) ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_last) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// hold until the output register is free
					if (rsp_free) begin
						valid_cnt_q <= cnt_next;
						span_sum_q  <= sum_next;
						next_seq_q  <= next_seq_q + fcskc_pkg::AGE_W'(1);
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	fcskc_pkg::req_word_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	fcskc_pkg::rsp_word_t rsp;
	logic cfg_we;
	logic [fcskc_pkg::LIMIT_W-1:0] cfg_data;

	fifo_cache_store_with_key_cap dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the cache table
	logic [fcskc_pkg::KEY_W-1:0]   key_copy [fcskc_pkg::TABLE_DEPTH];
	logic [fcskc_pkg::AGE_W-1:0]   age_copy [fcskc_pkg::TABLE_DEPTH];
	logic [fcskc_pkg::AGE_W-1:0]   seq_next;
	int                            used_count;
	logic [fcskc_pkg::SUM_W-1:0]   span_acc;
	logic [fcskc_pkg::LIMIT_W-1:0] cap_limit;

	fcskc_pkg::rsp_word_t pending_results[$];
	int                   mismatch_count = 0;
	int                   sender_idle_pct;
	int                   stall_pct;
	int                   stall_hold = 0;

	function automatic fcskc_pkg::rsp_word_t predict_store(input fcskc_pkg::req_word_t w);
		int                            same;
		int                            oldest;
		int                            slot;
		logic [fcskc_pkg::AGE_W-1:0]   min_age;
		logic [fcskc_pkg::SUM_W:0]     sum;
		logic                          repl;
		fcskc_pkg::rsp_word_t          r;
		same = 0;
		oldest = 0;
		min_age = '0;
		for (int i = 0; i < used_count; i++) begin
			if (key_copy[i] == w.entry_key)
				same++;
			// strict compare: lowest index wins a tie
			if (i == 0 || age_copy[i] < min_age) begin
				oldest = i;
				min_age = age_copy[i];
			end
		end
		repl = (used_count > 0) &&
			((same >= cap_limit) || (used_count >= fcskc_pkg::TABLE_DEPTH));
		if (repl) begin
			slot = oldest;
		end else begin
			sum = {1'b0, span_acc} + (fcskc_pkg::SUM_W + 1)'(w.span_length);
			span_acc = sum[fcskc_pkg::SUM_W] ? '1 : sum[fcskc_pkg::SUM_W-1:0];
			slot = used_count;
			used_count++;
		end
		key_copy[slot] = w.entry_key;
		age_copy[slot] = seq_next;
		seq_next = seq_next + fcskc_pkg::AGE_W'(1);
		r.slot_used = 6'(slot);
		r.replaced = repl;
		r.entry_count = 7'(used_count);
		r.span_total = span_acc;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch %s: want %h got %h at %0t", what, want, got, $time);
	endtask

	// check every word taken from the result channel
	always @(posedge clk) begin : check_rsp
		fcskc_pkg::rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 32'h0, rsp.span_total);
			end else begin
				want = pending_results.pop_front();
				if (rsp.slot_used !== want.slot_used)
					report_mismatch("slot_used", 32'(want.slot_used), 32'(rsp.slot_used));
				if (rsp.replaced !== want.replaced)
					report_mismatch("replaced", 32'(want.replaced), 32'(rsp.replaced));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(want.entry_count),
						32'(rsp.entry_count));
				if (rsp.span_total !== want.span_total)
					report_mismatch("span_total", want.span_total, rsp.span_total);
			end
		end
	end

	// receiver back-pressure, with an occasional long hold
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			rsp_stall <= 1'b1;
		end else if (stall_pct > 0 && $urandom_range(0, 1023) == 0) begin
			stall_hold <= int'($urandom_range(1, 40));
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_word(input fcskc_pkg::req_word_t w, input int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_results.push_back(predict_store(w));
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [fcskc_pkg::LIMIT_W-1:0] v);
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_limit = v;
	endtask

	task automatic send_fields(input logic [fcskc_pkg::KEY_W-1:0] k,
			input logic [fcskc_pkg::SPAN_W-1:0] s);
		fcskc_pkg::req_word_t w;
		w.entry_key = k;
		w.span_length = s;
		send_word(w, 0);
	endtask

	// empty table appends even with a zero limit; afterwards every store replaces
	task automatic test_zero_limit_on_empty();
		write_limit('0);
		send_fields(32'h0000_0000, 16'h0000);
		send_fields(32'hFFFF_FFFF, 16'hFFFF);
		send_fields(32'h0000_0000, 16'hFFFF);
	endtask

	task automatic test_key_cap();
		write_limit(7'd2);
		repeat (4) send_fields(32'h1234_5678, 16'h0100);
		write_limit(7'd1);
		send_fields(32'h1234_5678, 16'h0001);
		send_fields(32'h8765_4321, 16'h0002);
		send_fields(32'h8765_4321, 16'h0003);
	endtask

	task automatic test_field_extremes();
		write_limit(7'd64);
		send_fields(32'h0000_0000, 16'h0000);
		send_fields(32'hFFFF_FFFF, 16'hFFFF);
		send_fields(32'h5555_5555, 16'h5555);
		send_fields(32'hAAAA_AAAA, 16'hAAAA);
		send_fields(32'hFFFF_FFFF, 16'h0000);
		send_fields(32'h0000_0000, 16'hFFFF);
	endtask

	task automatic test_random_traffic(input logic [fcskc_pkg::LIMIT_W-1:0] lim,
			input int pool_n, input int idle_pct, input int rx_pct, input int items);
		logic [fcskc_pkg::KEY_W-1:0] pool [8];
		fcskc_pkg::req_word_t        w;
		int                          gap;
		write_limit(lim);
		sender_idle_pct = idle_pct;
		stall_pct = rx_pct;
		for (int i = 0; i < 8; i++)
			pool[i] = $urandom;
		for (int n = 0; n < items; n++) begin
			// hold off now and then until the block has drained
			if ($urandom_range(0, 49) == 0)
				wait_results_drained();
			gap = 0;
			if (sender_idle_pct > 0) begin
				if ($urandom_range(0, 9) == 0)
					gap = int'($urandom_range(0, 80));
				else
					while ($urandom_range(0, 99) < sender_idle_pct) gap++;
			end
			w.entry_key = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, pool_n - 1)]
				: $urandom;
			case ($urandom_range(0, 7))
				0: w.span_length = '0;
				1: w.span_length = '1;
				default: w.span_length = 16'($urandom_range(0, 65535));
			endcase
			send_word(w, gap);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		sender_idle_pct = 0;
		stall_pct = 0;
		seq_next = '0;
		used_count = 0;
		span_acc = '0;
		cap_limit = fcskc_pkg::LIMIT_RESET;
		for (int i = 0; i < fcskc_pkg::TABLE_DEPTH; i++) begin
			key_copy[i] = '0;
			age_copy[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_limit_on_empty();
		test_key_cap();
		test_field_extremes();

		test_random_traffic(7'd2, 3, 0, 0, 250);
		test_random_traffic(7'd1, 4, 56, 0, 250);
		test_random_traffic(7'($urandom_range(3, 8)), 6, 0, 56, 250);
		test_random_traffic(7'd0, 4, 25, 25, 200);
		test_random_traffic(7'd64, 8, 0, 0, 350);
		test_random_traffic(7'd127, 8, 56, 0, 250);
		test_random_traffic(7'($urandom_range(0, 127)), 8, 25, 25, 250);

		wait_results_drained();
		stall_pct = 0;
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("simulation failed");
		$finish;
	end

endmodule
